@@ src/gpf_pkg.sv @@
package gpf_pkg;

    localparam int PATH_DEPTH = 64;
    localparam int NODE_BITS  = 16;
    localparam int ADDR_BITS  = $clog2(PATH_DEPTH);
    localparam int COUNT_BITS = $clog2(PATH_DEPTH + 1);

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    typedef enum logic [1:0] {
        KIND_INIT = 2'd0,
        KIND_PATH = 2'd1,
        KIND_POS  = 2'd2,
        KIND_ARB  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        HEAD_YP = 2'd0,
        HEAD_YN = 2'd1,
        HEAD_XP = 2'd2,
        HEAD_XN = 2'd3
    } heading_t;

    // drive command codes; codes above CMD_RIGHT pass through on arbitration
    localparam logic [3:0] CMD_NONE       = 4'd0;
    localparam logic [3:0] CMD_STOP       = 4'd1;
    localparam logic [3:0] CMD_BACK_STOP  = 4'd2;
    localparam logic [3:0] CMD_LEFT_STOP  = 4'd3;
    localparam logic [3:0] CMD_RIGHT_STOP = 4'd4;
    localparam logic [3:0] CMD_FWD        = 4'd5;
    localparam logic [3:0] CMD_BACK       = 4'd6;
    localparam logic [3:0] CMD_LEFT       = 4'd7;
    localparam logic [3:0] CMD_RIGHT      = 4'd8;

    localparam logic [PADDR_BITS-1:0] ADDR_START_HEADING = PADDR_BITS'(0);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_HEAD = 2'd1,
        ST_EXEC = 2'd2
    } state_t;

    typedef struct packed {
        logic load_item;
        logic cap_cur;
        logic rd_next;
        logic commit;
    } gpf_ctrl_t;

    typedef struct packed {
        logic out_free;
    } gpf_status_t;

    // command for a heading change
    function automatic logic [3:0] turn_cmd(heading_t new_h, heading_t old_h);
        logic [3:0] cmd;
        cmd = CMD_FWD;
        if (new_h == old_h)
        begin
            cmd = CMD_FWD;
        end
        else
        begin
            unique case (new_h)
                HEAD_YP: cmd = (old_h == HEAD_YN) ? CMD_BACK :
                               (old_h == HEAD_XP) ? CMD_LEFT : CMD_RIGHT;
                HEAD_YN: cmd = (old_h == HEAD_YP) ? CMD_BACK :
                               (old_h == HEAD_XP) ? CMD_RIGHT : CMD_LEFT;
                HEAD_XP: cmd = (old_h == HEAD_YP) ? CMD_RIGHT :
                               (old_h == HEAD_YN) ? CMD_LEFT : CMD_BACK;
                HEAD_XN: cmd = (old_h == HEAD_YP) ? CMD_LEFT :
                               (old_h == HEAD_YN) ? CMD_RIGHT : CMD_BACK;
                default: cmd = CMD_FWD;
            endcase
        end
        return cmd;
    endfunction

    // final stop with empty path depends on heading
    function automatic logic [3:0] stop_cmd(heading_t h);
        logic [3:0] cmd;
        cmd = CMD_STOP;
        unique case (h)
            HEAD_YP: cmd = CMD_STOP;
            HEAD_YN: cmd = CMD_BACK_STOP;
            HEAD_XP: cmd = CMD_LEFT_STOP;
            HEAD_XN: cmd = CMD_RIGHT_STOP;
            default: cmd = CMD_STOP;
        endcase
        return cmd;
    endfunction

endpackage

@@ src/gpf_if.sv @@
interface gpf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        enable;
    logic [15:0] node_number;
    logic        first_of_path;
    logic [15:0] position;
    logic [3:0]  override_command;

    modport source (
        output valid, kind, enable, node_number, first_of_path, position,
               override_command,
        input  ready
    );
    modport sink (
        input  valid, kind, enable, node_number, first_of_path, position,
               override_command,
        output ready
    );
endinterface

interface gpf_result_if;
    logic       valid;
    logic       ready;
    logic       ready_res;
    logic       busy_res;
    logic [3:0] drive_command;
    logic       task_done;
    logic       confirm;
    logic       init_ack;
    logic       path_overflow;

    modport source (
        output valid, ready_res, busy_res, drive_command, task_done, confirm,
               init_ack, path_overflow,
        input  ready
    );
    modport sink (
        input  valid, ready_res, busy_res, drive_command, task_done, confirm,
               init_ack, path_overflow,
        output ready
    );
endinterface

@@ src/gpf_ram.sv @@
module gpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/gpf_ctrl.sv @@
module gpf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  gpf_pkg::gpf_status_t status,
    output gpf_pkg::gpf_ctrl_t  ctrl
);

    gpf_pkg::state_t state_reg;
    gpf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gpf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gpf_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = gpf_pkg::ST_HEAD;
                end
            end
            gpf_pkg::ST_HEAD:
            begin
                state_next = gpf_pkg::ST_EXEC;
            end
            gpf_pkg::ST_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = gpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready     = 1'b0;
        ctrl.load_item = 1'b0;
        ctrl.cap_cur   = 1'b0;
        ctrl.rd_next   = 1'b0;
        ctrl.commit    = 1'b0;
        unique case (state_reg)
            gpf_pkg::ST_IDLE:
            begin
                item_ready     = 1'b1;
                ctrl.load_item = item_valid;
            end
            gpf_pkg::ST_HEAD:
            begin
                ctrl.cap_cur = 1'b1;
                ctrl.rd_next = 1'b1;
            end
            gpf_pkg::ST_EXEC:
            begin
                ctrl.rd_next = 1'b1;
                ctrl.commit  = status.out_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // an accepted beat passes through the head step, with no commit, into the execute step
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_item |=> !ctrl.commit ##1 (state_reg == gpf_pkg::ST_EXEC))
        else $error("item did not reach the execute step in order");

endmodule

@@ src/gpf_dp.sv @@
module gpf_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gpf_pkg::gpf_ctrl_t                   ctrl,
    output gpf_pkg::gpf_status_t                 status,
    // item payload
    input  logic [1:0]                           kind,
    input  logic                                 enable,
    input  logic [15:0]                          node_number,
    input  logic                                 first_of_path,
    input  logic [15:0]                          position,
    input  logic [3:0]                           override_command,
    // configuration
    input  logic                                 cfg_wr,
    input  logic [1:0]                           cfg_heading,
    output logic [1:0]                           start_heading,
    // result
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic                                 ready_res,
    output logic                                 busy_res,
    output logic [3:0]                           drive_command,
    output logic                                 task_done,
    output logic                                 confirm,
    output logic                                 init_ack,
    output logic                                 path_overflow
);

    localparam int SUM_BITS = gpf_pkg::COUNT_BITS + 1;

    // latched item
    gpf_pkg::kind_t                    kind_reg;
    logic                              enable_reg;
    logic [gpf_pkg::NODE_BITS-1:0]     node_reg;
    logic                              first_reg;
    logic [gpf_pkg::NODE_BITS-1:0]     pos_reg;
    logic [3:0]                        ovr_reg;
    logic [gpf_pkg::NODE_BITS-1:0]     cur_reg;

    // architectural state
    logic                              started_reg, started_next;
    logic                              hold_reg, hold_next;
    gpf_pkg::heading_t                 heading_reg, heading_next;
    logic [1:0]                        start_heading_reg;
    logic [gpf_pkg::ADDR_BITS-1:0]     head_reg, head_next;
    logic [gpf_pkg::COUNT_BITS-1:0]    count_reg, count_next;
    logic [3:0]                        cmd_reg, cmd_next;
    logic                              ready_reg, ready_next;
    logic                              busy_reg, busy_next;

    logic                              out_valid_reg;
    logic                              done_reg, conf_reg, ack_reg, ovf_reg;
    logic                              done_next, conf_next, ack_next, ovf_next;

    logic [gpf_pkg::NODE_BITS-1:0]     nxt_node;
    logic [gpf_pkg::ADDR_BITS-1:0]     head_plus1;
    logic [gpf_pkg::ADDR_BITS-1:0]     tail_addr;
    logic [gpf_pkg::ADDR_BITS-1:0]     rd_addr;
    logic [gpf_pkg::ADDR_BITS-1:0]     wr_addr;
    logic                              wr_en;
    logic [SUM_BITS-1:0]               tail_sum;
    logic [SUM_BITS-1:0]               inc_sum;
    logic [gpf_pkg::NODE_BITS:0]       cur_p1;
    logic [gpf_pkg::NODE_BITS:0]       nxt_p1;
    logic                              at_head;
    logic                              full;

    // wrap head + count and head + 1 into the store
    always_comb
    begin
        tail_sum = SUM_BITS'(head_reg) + SUM_BITS'(count_reg);
        if (tail_sum >= SUM_BITS'(gpf_pkg::PATH_DEPTH))
        begin
            tail_sum = tail_sum - SUM_BITS'(gpf_pkg::PATH_DEPTH);
        end
        tail_addr = tail_sum[gpf_pkg::ADDR_BITS-1:0];

        inc_sum = SUM_BITS'(head_reg) + SUM_BITS'(1);
        if (inc_sum >= SUM_BITS'(gpf_pkg::PATH_DEPTH))
        begin
            inc_sum = inc_sum - SUM_BITS'(gpf_pkg::PATH_DEPTH);
        end
        head_plus1 = inc_sum[gpf_pkg::ADDR_BITS-1:0];
    end

    assign rd_addr = ctrl.rd_next ? head_plus1 : head_reg;
    assign full    = !first_reg && (count_reg == gpf_pkg::COUNT_BITS'(gpf_pkg::PATH_DEPTH));
    assign wr_en   = ctrl.commit && started_reg && (kind_reg == gpf_pkg::KIND_PATH) && !full;
    assign wr_addr = first_reg ? '0 : tail_addr;

    gpf_ram #(
        .WIDTH (gpf_pkg::NODE_BITS),
        .DEPTH (gpf_pkg::PATH_DEPTH)
    ) u_path_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (node_reg),
        .raddr (rd_addr),
        .rdata (nxt_node)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            kind_reg   <= gpf_pkg::kind_t'(kind);
            enable_reg <= enable;
            node_reg   <= gpf_pkg::NODE_BITS'(node_number);
            first_reg  <= first_of_path;
            pos_reg    <= gpf_pkg::NODE_BITS'(position);
            ovr_reg    <= override_command;
        end
        if (ctrl.cap_cur)
        begin
            cur_reg <= nxt_node;
        end
    end

    assign at_head = (pos_reg == cur_reg);
    assign cur_p1  = {1'b0, cur_reg} + (gpf_pkg::NODE_BITS + 1)'(1);
    assign nxt_p1  = {1'b0, nxt_node} + (gpf_pkg::NODE_BITS + 1)'(1);

    always_comb
    begin
        started_next = started_reg;
        hold_next    = hold_reg;
        heading_next = heading_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        ready_next   = ready_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        conf_next    = 1'b0;
        ack_next     = 1'b0;
        ovf_next     = 1'b0;

        if (!started_reg)
        begin
            if ((kind_reg == gpf_pkg::KIND_INIT) && enable_reg)
            begin
                started_next = 1'b1;
                ready_next   = 1'b1;
                ack_next     = 1'b1;
            end
        end
        else
        begin
            unique case (kind_reg)
                gpf_pkg::KIND_INIT:
                begin
                    if (!enable_reg)
                    begin
                        started_next = 1'b0;
                        ready_next   = 1'b0;
                        ack_next     = 1'b1;
                    end
                end
                gpf_pkg::KIND_PATH:
                begin
                    busy_next  = 1'b1;
                    ready_next = enable_reg;
                    if (first_reg)
                    begin
                        head_next = '0;
                    end
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (first_reg)
                    begin
                        count_next = gpf_pkg::COUNT_BITS'(1);
                    end
                    else
                    begin
                        count_next = count_reg + gpf_pkg::COUNT_BITS'(1);
                    end
                end
                gpf_pkg::KIND_POS:
                begin
                    conf_next = 1'b1;
                    if (!hold_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            cmd_next  = gpf_pkg::stop_cmd(heading_reg);
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                        else if (count_reg == gpf_pkg::COUNT_BITS'(1))
                        begin
                            if (at_head)
                            begin
                                cmd_next   = gpf_pkg::CMD_STOP;
                                head_next  = head_plus1;
                                count_next = count_reg - gpf_pkg::COUNT_BITS'(1);
                            end
                            else
                            begin
                                cmd_next = gpf_pkg::CMD_FWD;
                            end
                        end
                        else if (at_head)
                        begin
                            // unit step is along X, longer step along Y
                            priority if (nxt_node == cur_p1[gpf_pkg::NODE_BITS-1:0]
                                         && !cur_p1[gpf_pkg::NODE_BITS])
                            begin
                                heading_next = gpf_pkg::HEAD_XP;
                                cmd_next = gpf_pkg::turn_cmd(gpf_pkg::HEAD_XP, heading_reg);
                            end
                            else if (cur_reg == nxt_p1[gpf_pkg::NODE_BITS-1:0]
                                     && !nxt_p1[gpf_pkg::NODE_BITS])
                            begin
                                heading_next = gpf_pkg::HEAD_XN;
                                cmd_next = gpf_pkg::turn_cmd(gpf_pkg::HEAD_XN, heading_reg);
                            end
                            else if (nxt_node > cur_reg)
                            begin
                                heading_next = gpf_pkg::HEAD_YP;
                                cmd_next = gpf_pkg::turn_cmd(gpf_pkg::HEAD_YP, heading_reg);
                            end
                            else if (nxt_node < cur_reg)
                            begin
                                heading_next = gpf_pkg::HEAD_YN;
                                cmd_next = gpf_pkg::turn_cmd(gpf_pkg::HEAD_YN, heading_reg);
                            end
                            else
                            begin
                                // zero step keeps heading and command
                                heading_next = heading_reg;
                            end
                            head_next  = head_plus1;
                            count_next = count_reg - gpf_pkg::COUNT_BITS'(1);
                        end
                    end
                end
                gpf_pkg::KIND_ARB:
                begin
                    hold_next = !hold_reg;
                    cmd_next  = ovr_reg;
                    conf_next = 1'b1;
                end
                default:
                begin
                    conf_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg       <= 1'b0;
            hold_reg          <= 1'b0;
            heading_reg       <= gpf_pkg::HEAD_YP;
            start_heading_reg <= 2'd0;
            head_reg          <= '0;
            count_reg         <= '0;
            cmd_reg           <= gpf_pkg::CMD_NONE;
            ready_reg         <= 1'b0;
            busy_reg          <= 1'b0;
        end
        else if (cfg_wr)
        begin
            start_heading_reg <= cfg_heading;
            heading_reg       <= gpf_pkg::heading_t'(cfg_heading);
        end
        else if (ctrl.commit)
        begin
            started_reg <= started_next;
            hold_reg    <= hold_next;
            heading_reg <= heading_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            cmd_reg     <= cmd_next;
            ready_reg   <= ready_next;
            busy_reg    <= busy_next;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            done_reg <= done_next;
            conf_reg <= conf_next;
            ack_reg  <= ack_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign status.out_free = !out_valid_reg || res_ready;
    assign start_heading   = start_heading_reg;
    assign res_valid       = out_valid_reg;
    assign ready_res       = ready_reg;
    assign busy_res        = busy_reg;
    assign drive_command   = cmd_reg;
    assign task_done       = done_reg;
    assign confirm         = conf_reg;
    assign init_ack        = ack_reg;
    assign path_overflow   = ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= gpf_pkg::COUNT_BITS'(gpf_pkg::PATH_DEPTH))
        else $error("path count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> out_valid_reg)
        else $error("commit without a result beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> started_reg && !ovf_next)
        else $error("store written while stopped or full");

    assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.commit |=> $stable(count_reg) && $stable(head_reg))
        else $error("path queue moved without a commit");

endmodule

@@ src/grid_path_follower.sv @@
// channel  | dir  | beat                                        | handshake
// item     | in   | kind enable node_number first_of_path       | valid/ready
//          |      | position override_command                   |
// result   | out  | ready_res busy_res drive_command task_done  | valid/ready
//          |      | confirm init_ack path_overflow              |
// apb      | in   | start_heading at byte 0                     | psel/penable
//
// an item is accepted in idle, the head node is read, then the next node is read
// and the update commits; the result beat is registered from that commit. the
// single read port of the path store splits the two reads. one result beat per item.
// rst_n clears control state at once; the path store needs no clearing.
// a result waiting on result.ready stalls the update step, and item.ready
// stays low until the block is back in idle.
module grid_path_follower (
    input  logic                           clk,
    input  logic                           rst_n,
    gpf_item_if.sink                       item,
    gpf_result_if.source                   result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gpf_pkg::PADDR_BITS-1:0] paddr,
    input  logic [gpf_pkg::PDATA_BITS-1:0] pwdata,
    output logic [gpf_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready
);

    gpf_pkg::gpf_ctrl_t   ctrl;
    gpf_pkg::gpf_status_t status;
    logic                 cfg_wr;
    logic [1:0]           start_heading;

    // register decode on the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[gpf_pkg::PADDR_BITS-1:2]
                        == gpf_pkg::ADDR_START_HEADING[gpf_pkg::PADDR_BITS-1:2]);
    assign prdata = (paddr[gpf_pkg::PADDR_BITS-1:2]
                     == gpf_pkg::ADDR_START_HEADING[gpf_pkg::PADDR_BITS-1:2])
                    ? gpf_pkg::PDATA_BITS'(start_heading) : '0;

    gpf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .ctrl       (ctrl)
    );

    gpf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .status           (status),
        .kind             (item.kind),
        .enable           (item.enable),
        .node_number      (item.node_number),
        .first_of_path    (item.first_of_path),
        .position         (item.position),
        .override_command (item.override_command),
        .cfg_wr           (cfg_wr),
        .cfg_heading      (pwdata[1:0]),
        .start_heading    (start_heading),
        .res_valid        (result.valid),
        .res_ready        (result.ready),
        .ready_res        (result.ready_res),
        .busy_res         (result.busy_res),
        .drive_command    (result.drive_command),
        .task_done        (result.task_done),
        .confirm          (result.confirm),
        .init_ack         (result.init_ack),
        .path_overflow    (result.path_overflow)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        gpf_pkg::kind_t kind;
        logic           enable;
        logic [15:0]    node_number;
        logic           first_of_path;
        logic [15:0]    position;
        logic [3:0]     override_command;
    } item_t;

    typedef struct packed {
        logic       ready_res;
        logic       busy_res;
        logic [3:0] drive_command;
        logic       task_done;
        logic       confirm;
        logic       init_ack;
        logic       path_overflow;
    } result_t;

    // keeps its own copy of the follower state and the results still owed
    class path_scoreboard;
        logic                           started;
        logic                           hold;
        gpf_pkg::heading_t              heading;
        logic [15:0]                    store [gpf_pkg::PATH_DEPTH];
        logic [gpf_pkg::ADDR_BITS-1:0]  head;
        logic [gpf_pkg::COUNT_BITS-1:0] count;
        logic [3:0]                     command;
        logic                           ready_q;
        logic                           busy_q;
        result_t                        due [$];
        int                             errors;
        int                             n_done;
        int                             n_ovf;
        int                             n_hold;

        function new();
            started = 1'b0;
            hold    = 1'b0;
            heading = gpf_pkg::HEAD_YP;
            head    = '0;
            count   = '0;
            command = gpf_pkg::CMD_NONE;
            ready_q = 1'b0;
            busy_q  = 1'b0;
            errors  = 0;
            n_done  = 0;
            n_ovf   = 0;
            n_hold  = 0;
            foreach (store[i])
                store[i] = '0;
        endfunction

        function void load_heading(gpf_pkg::heading_t h);
            heading = h;
        endfunction

        function logic [3:0] turn_for(gpf_pkg::heading_t new_dir,
                                      gpf_pkg::heading_t old_dir);
            if (new_dir == old_dir)
                return gpf_pkg::CMD_FWD;
            // opposite directions differ only in the low bit
            if ((new_dir ^ old_dir) == 2'b01)
                return gpf_pkg::CMD_BACK;
            case ({new_dir, old_dir})
                {gpf_pkg::HEAD_YP, gpf_pkg::HEAD_XP}, {gpf_pkg::HEAD_YN, gpf_pkg::HEAD_XN},
                {gpf_pkg::HEAD_XP, gpf_pkg::HEAD_YN}, {gpf_pkg::HEAD_XN, gpf_pkg::HEAD_YP}:
                    return gpf_pkg::CMD_LEFT;
                default:
                    return gpf_pkg::CMD_RIGHT;
            endcase
        endfunction

        // position report, returns the task-done pulse
        function logic follow(logic [15:0] pos);
            logic [15:0]       cur;
            logic [15:0]       nxt;
            int                step;
            gpf_pkg::heading_t dir;
            if (hold)
                return 1'b0;
            if (count == 0)
            begin
                command = gpf_pkg::CMD_STOP + 4'(heading);
                busy_q  = 1'b0;
                return 1'b1;
            end
            cur = store[head];
            if (pos != cur)
            begin
                if (count == 1)
                    command = gpf_pkg::CMD_FWD;
                return 1'b0;
            end
            if (count == 1)
                command = gpf_pkg::CMD_STOP;
            else
            begin
                nxt  = store[gpf_pkg::ADDR_BITS'(head + 1)];
                step = int'(nxt) - int'(cur);
                if (step != 0)
                begin
                    if (step > 1)
                        dir = gpf_pkg::HEAD_YP;
                    else if (step < -1)
                        dir = gpf_pkg::HEAD_YN;
                    else if (step == 1)
                        dir = gpf_pkg::HEAD_XP;
                    else
                        dir = gpf_pkg::HEAD_XN;
                    command = turn_for(dir, heading);
                    heading = dir;
                end
            end
            head  = head + 1'b1;
            count = count - 1'b1;
            return 1'b0;
        endfunction

        function void note_item(item_t it);
            result_t r;
            r = '0;
            if (!started)
            begin
                if (it.kind == gpf_pkg::KIND_INIT && it.enable)
                begin
                    started   = 1'b1;
                    ready_q   = 1'b1;
                    r.init_ack = 1'b1;
                end
            end
            else
            begin
                case (it.kind)
                    gpf_pkg::KIND_INIT:
                    begin
                        if (!it.enable)
                        begin
                            started    = 1'b0;
                            ready_q    = 1'b0;
                            r.init_ack = 1'b1;
                        end
                    end
                    gpf_pkg::KIND_PATH:
                    begin
                        busy_q  = 1'b1;
                        ready_q = it.enable;
                        if (it.first_of_path)
                        begin
                            head  = '0;
                            count = '0;
                        end
                        if (count < gpf_pkg::PATH_DEPTH)
                        begin
                            store[gpf_pkg::ADDR_BITS'(head + count)] = it.node_number;
                            count = count + 1'b1;
                        end
                        else
                        begin
                            r.path_overflow = 1'b1;
                            n_ovf++;
                        end
                    end
                    gpf_pkg::KIND_POS:
                    begin
                        r.task_done = follow(it.position);
                        r.confirm   = 1'b1;
                    end
                    default:
                    begin
                        hold      = !hold;
                        command   = it.override_command;
                        r.confirm = 1'b1;
                        n_hold++;
                    end
                endcase
            end
            r.ready_res     = ready_q;
            r.busy_res      = busy_q;
            r.drive_command = command;
            if (r.task_done)
                n_done++;
            due.insert(due.size(), r);
        endfunction

        function string describe(result_t r);
            return $sformatf("rdy %0b busy %0b cmd %0d done %0b conf %0b ack %0b ovf %0b",
                             r.ready_res, r.busy_res, r.drive_command, r.task_done,
                             r.confirm, r.init_ack, r.path_overflow);
        endfunction

        function void report(string what, result_t want, result_t got);
            errors++;
            if (errors <= 10)
                $display("%s: expected %s, got %s", what, describe(want), describe(got));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due.size() == 0)
            begin
                report("result with nothing owed", '0, got);
                return;
            end
            want = due.pop_front();
            if (got.ready_res !== want.ready_res || got.busy_res !== want.busy_res ||
                got.drive_command !== want.drive_command ||
                got.task_done !== want.task_done || got.confirm !== want.confirm ||
                got.init_ack !== want.init_ack || got.path_overflow !== want.path_overflow)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [gpf_pkg::PADDR_BITS-1:0] paddr;
    logic [gpf_pkg::PDATA_BITS-1:0] pwdata;
    logic [gpf_pkg::PDATA_BITS-1:0] prdata;
    logic                           pready;

    gpf_item_if   item_ch ();
    gpf_result_if res_ch ();

    grid_path_follower u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    path_scoreboard    sb;
    int                items_sent    = 0;
    int                results_seen  = 0;
    int                stall_left    = 0;
    int                quiet_cycles  = 0;
    logic              pressure_done = 1'b0;
    logic              calm          = 1'b0;
    logic              tx_idle       = 1'b1;
    logic              rx_busy       = 1'b1;
    gpf_pkg::heading_t plan [4];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t any_item();
        item_t it;
        it.kind             = gpf_pkg::kind_t'($urandom_range(0, 3));
        it.enable           = 1'($urandom);
        it.node_number      = 16'($urandom);
        it.first_of_path    = 1'($urandom);
        it.position         = 16'($urandom);
        it.override_command = 4'($urandom);
        return it;
    endfunction

    function automatic item_t mk_init(logic en);
        item_t it;
        it        = any_item();
        it.kind   = gpf_pkg::KIND_INIT;
        it.enable = en;
        return it;
    endfunction

    function automatic item_t mk_node(logic [15:0] n, logic fresh, logic en);
        item_t it;
        it               = any_item();
        it.kind          = gpf_pkg::KIND_PATH;
        it.node_number   = n;
        it.first_of_path = fresh;
        it.enable        = en;
        return it;
    endfunction

    function automatic item_t mk_pos(logic [15:0] p);
        item_t it;
        it          = any_item();
        it.kind     = gpf_pkg::KIND_POS;
        it.position = p;
        return it;
    endfunction

    function automatic item_t mk_arb(logic [3:0] c);
        item_t it;
        it                  = any_item();
        it.kind             = gpf_pkg::KIND_ARB;
        it.override_command = c;
        return it;
    endfunction

    function automatic logic [15:0] next_node(logic [15:0] n);
        case ($urandom_range(0, 6))
            0:       return n + 16'd1;
            1:       return n - 16'd1;
            2:       return n + 16'($urandom_range(2, 3000));
            3:       return n - 16'($urandom_range(2, 3000));
            4:       return n;
            5:       return n + 16'd2;
            default: return 16'($urandom);
        endcase
    endfunction

    // called just after a rising edge; returns at the edge that took the beat, or after a random idle gap
    task automatic send(input item_t it);
        int gap;
        item_ch.valid            <= 1'b1;
        item_ch.kind             <= it.kind;
        item_ch.enable           <= it.enable;
        item_ch.node_number      <= it.node_number;
        item_ch.first_of_path    <= it.first_of_path;
        item_ch.position         <= it.position;
        item_ch.override_command <= it.override_command;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        sb.note_item(it);
        items_sent++;
        if (!calm && tx_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_heading(input gpf_pkg::heading_t h);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gpf_pkg::ADDR_START_HEADING;
        pwdata  <= gpf_pkg::PDATA_BITS'(h);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.load_heading(h);
    endtask

    // wait for every owed result, then let the pipeline go quiet
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic run_directed();
        send(mk_pos(16'd0));
        send(mk_node(16'd5, 1'b1, 1'b1));
        send(mk_arb(gpf_pkg::CMD_RIGHT));
        send(mk_init(1'b0));
        send(mk_init(1'b1));
        send(mk_init(1'b1));
        send(mk_pos(16'hffff));
        send(mk_node(16'd0, 1'b1, 1'b1));
        send(mk_node(16'd1, 1'b0, 1'b1));
        send(mk_node(16'hffff, 1'b0, 1'b1));
        send(mk_node(16'hffff, 1'b0, 1'b1));
        send(mk_node(16'hfffe, 1'b0, 1'b1));
        send(mk_node(16'd100, 1'b0, 1'b0));
        send(mk_pos(16'd5));
        send(mk_pos(16'd0));
        send(mk_pos(16'd1));
        send(mk_pos(16'hffff));
        send(mk_arb(4'hf));
        send(mk_pos(16'hffff));
        send(mk_arb(gpf_pkg::CMD_NONE));
        send(mk_pos(16'hffff));
        send(mk_pos(16'hfffe));
        send(mk_pos(16'd7));
        send(mk_pos(16'd100));
        send(mk_pos(16'd100));
        send(mk_init(1'b0));
    endtask

    // load a path, then report positions along it
    task automatic run_route();
        int          len;
        int          walk;
        int          r;
        logic [15:0] node;
        logic        fresh;
        if (!sb.started)
            send(mk_init(1'b1));
        if (sb.hold)
            send(mk_arb(4'($urandom)));
        len     = ($urandom_range(0, 11) == 0) ? $urandom_range(64, 68) : $urandom_range(1, 8);
        fresh   = ($urandom_range(0, 4) != 0);
        node    = 16'($urandom);
        tx_idle = 1'($urandom);
        for (int i = 0; i < len; i++)
        begin
            send(mk_node(node, fresh && i == 0, $urandom_range(0, 9) != 0));
            node = next_node(node);
        end
        walk = (len > 8) ? $urandom_range(3, 10) : int'(sb.count) + 1 + $urandom_range(0, 1);
        for (int i = 0; i < walk; i++)
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
            begin
                send(mk_arb(4'($urandom)));
                send(mk_pos(sb.store[sb.head]));
                send(mk_arb(4'($urandom)));
            end
            else if (r == 1)
                send(mk_pos(16'($urandom)));
            else
                send(mk_pos(sb.store[sb.head]));
        end
    endtask

    task automatic run_random(input int n, input logic closing);
        int target;
        int r;
        target = items_sent + n;
        while (items_sent < target)
        begin
            if (closing && target - items_sent < 60)
                calm = 1'b1;
            r = $urandom_range(0, 19);
            if (r == 0)
                send(any_item());
            else if (r == 1)
                send(mk_init(1'($urandom)));
            else if (r == 2)
                send(mk_arb(4'($urandom)));
            else
                run_route();
        end
    endtask

    initial
    begin
        sb                       = new();
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        item_ch.valid            = 1'b0;
        item_ch.kind             = gpf_pkg::KIND_INIT;
        item_ch.enable           = 1'b0;
        item_ch.node_number      = '0;
        item_ch.first_of_path    = 1'b0;
        item_ch.position         = '0;
        item_ch.override_command = gpf_pkg::CMD_NONE;
        res_ch.ready             = 1'b0;
        plan[0] = gpf_pkg::HEAD_YP;
        plan[1] = gpf_pkg::HEAD_XP;
        plan[2] = gpf_pkg::heading_t'($urandom_range(0, 3));
        plan[3] = gpf_pkg::HEAD_YN;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_heading(gpf_pkg::HEAD_XN);
        run_directed();
        for (int p = 0; p < 4; p++)
        begin
            settle();
            set_heading(plan[p]);
            run_random(110, p == 3);
        end
        settle();
        $display("sent %0d items and checked %0d results under five heading settings",
                 items_sent, results_seen);
        $display("dropped path nodes %0d, task-done pulses %0d, hold toggles %0d",
                 sb.n_ovf, sb.n_done, sb.n_hold);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("testbench passed");
        else
        begin
            $display("%0d failures", sb.errors);
            $display("testbench failed");
        end
        $finish;
    end

    // result side: check each beat, stall in bursts, one long hold-off
    always @(posedge clk)
    begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            sb.check_result({res_ch.ready_res, res_ch.busy_res, res_ch.drive_command,
                             res_ch.task_done, res_ch.confirm, res_ch.init_ack,
                             res_ch.path_overflow});
            results_seen++;
        end
        if (stall_left > 0)
            stall_left--;
        else if (!pressure_done && results_seen >= 150)
        begin
            pressure_done = 1'b1;
            stall_left    = 400;
        end
        else if (!calm && rx_busy && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 19);
        if ($urandom_range(0, 63) == 0)
            rx_busy = !rx_busy;
        res_ch.ready <= (stall_left == 0);
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 1500)
        begin
            $display("no beat on either channel for %0d cycles", quiet_cycles);
            $display("testbench failed");
            $finish;
        end
    end

endmodule

@@ grid_path_follower.f @@
src/gpf_pkg.sv
src/gpf_if.sv
src/gpf_ram.sv
src/gpf_ctrl.sv
src/gpf_dp.sv
src/grid_path_follower.sv
tb/testbench.sv
